// ----- hw/rtl/glms_pkg.sv -----
`timescale 1ns / 1ps

package glms_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET  = 8'd128;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_CAP = 8'd128;

  // row position, up to 128 rows
  localparam int unsigned ROW_W = 7;

  // frame total
  localparam int unsigned           SUM_W   = 18;
  localparam logic [SUM_W-1:0]      SUM_MAX = 18'h3FFFF;

endpackage

// ----- hw/rtl/glms_ram.sv -----
`timescale 1ns / 1ps

module glms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ----- hw/rtl/grid_local_minimum_sum.sv -----
`timescale 1ns / 1ps

// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+------------------------------
// input    | in        | in_valid_i / in_stall_o   | elevation_i
// output   | out       | out_valid_o / out_stall_i | minimum_sum_o
// config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one cell per cycle while the input is not stalled; a cell is decided in stage 1 after its
// transfer, and a frame total is registered in the output register as its cell leaves stage 1.
// after reset the line store is swept to zero, entry by entry, input stalled meanwhile.
// apart from the sweep, the input stalls only while a frame total is held in the output
// register and the next frame total is waiting behind it.
// configuration is always taken; a write to frame width or height restarts the frame.

module grid_local_minimum_sum #(
  parameter int unsigned MAX_WIDTH      = 128,
  parameter int unsigned ELEVATION_BITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // cell stream
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ELEVATION_BITS-1:0]         elevation_i,
  // frame totals
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [glms_pkg::SUM_W-1:0]        minimum_sum_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [glms_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [glms_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int unsigned EB = ELEVATION_BITS;
  localparam int unsigned XW = glms_pkg::SUM_W + 1;

  // position flags worked out at transfer time and carried with the cell
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic has_right;
    logic last_row;
    logic last_col;
    logic frame_end;
    logic fwd_a;
    logic fwd_b;
  } s1_flags_t;

  // configuration
  logic [glms_pkg::CFG_DATA_W-1:0] width_q, height_q;
  logic [WW-1:0]                   width_ext, width_max, width_eff;
  logic [glms_pkg::CFG_DATA_W-1:0] height_eff;
  logic                            cfg_xfer, cfg_hit;

  // raster position of the next cell
  logic [AW-1:0]                   col_q, col_d;
  logic [glms_pkg::ROW_W-1:0]      row_q, row_d;
  logic                            last_col, last_row;
  logic [AW-1:0]                   addr_b;

  // reset sweep of the line store
  logic                            clr_busy_q;
  logic [AW-1:0]                   clr_addr_q;

  // stage 1
  logic                            in_xfer, s1_adv, s1_wr;
  logic                            s1_valid_q;
  s1_flags_t                       s1_q, s1_d;
  logic [EB-1:0]                   s1_elev_q;
  logic [AW-1:0]                   s1_col_q;

  // line store: upper half is the row two back, lower half the previous row
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [2*EB-1:0]                 ram_wdata, rd_a, rd_b, word_a, word_b, wr_word, fwd_data_q;
  logic [EB-1:0]                   nc, oc, nc1;
  logic [EB-1:0]                   prev_newer_q, tail0_q, tail1_q;

  // decisions and sum
  logic                            dec_lower, dec_left, dec_self;
  logic [XW-1:0]                   add_lower, add_left, add_self, add_sum;
  logic [glms_pkg::SUM_W-1:0]      total_q, total_sat;

  // output register
  logic                            out_valid_q;
  logic [glms_pkg::SUM_W-1:0]      out_sum_q;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;
  assign cfg_hit     = cfg_xfer &
                       ((cfg_index_i == glms_pkg::REG_FRAME_WIDTH) ||
                        (cfg_index_i == glms_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= glms_pkg::CFG_RESET;
      height_q <= glms_pkg::CFG_RESET;
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        glms_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        glms_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize is capped
  assign width_ext = WW'(width_q);
  assign width_max = WW'(MAX_WIDTH);
  assign width_eff = (width_q == '0)         ? WW'(1)    :
                     (width_ext > width_max) ? width_max : width_ext;
  assign height_eff = (height_q == '0)                 ? 8'd1                 :
                      (height_q > glms_pkg::HEIGHT_CAP) ? glms_pkg::HEIGHT_CAP : height_q;

  // ---------------------------------------------------------------------------
  // raster position
  // ---------------------------------------------------------------------------
  assign last_col = (WW'(col_q) + WW'(1)) == width_eff;
  assign last_row = ({1'b0, row_q} + 8'd1) == height_eff;
  // right-hand neighbour read, parked on entry zero at the end of a row
  assign addr_b   = last_col ? '0 : col_q + AW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_xfer) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + glms_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // reset sweep: one line store entry per cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  // stage 1 only waits when it carries a frame total and the output slot is held
  assign s1_adv     = ~(s1_q.frame_end & out_valid_q & out_stall_i);
  assign s1_wr      = s1_valid_q & s1_adv;
  assign in_stall_o = clr_busy_q | (s1_valid_q & ~s1_adv);
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------------------
  // line store
  // ---------------------------------------------------------------------------
  assign ram_we    = clr_busy_q | s1_wr;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_col_q;
  assign ram_wdata = clr_busy_q ? '0 : wr_word;

  glms_ram #(
    .WIDTH (2 * EB),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (in_xfer),
    .raddr_a_i (col_q),
    .raddr_b_i (addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // ---------------------------------------------------------------------------
  // stage 1 register
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_d.row_ge1   = row_q != '0;
    s1_d.row_ge2   = row_q > glms_pkg::ROW_W'(1);
    s1_d.col_ge1   = col_q != '0;
    s1_d.col_ge2   = col_q > AW'(1);
    s1_d.has_right = ~last_col;
    s1_d.last_row  = last_row;
    s1_d.last_col  = last_col;
    s1_d.frame_end = last_col & last_row;
    // the cell leaving stage 1 writes in the same edge as this read: forward it
    s1_d.fwd_a     = s1_wr & (s1_col_q == col_q);
    s1_d.fwd_b     = s1_wr & (s1_col_q == addr_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q       <= s1_d;
      s1_elev_q  <= elevation_i;
      s1_col_q   <= col_q;
      fwd_data_q <= wr_word;
    end
  end

  // store words with forwarding
  assign word_a  = s1_q.fwd_a ? fwd_data_q : rd_a;
  assign word_b  = s1_q.fwd_b ? fwd_data_q : rd_b;
  assign nc      = word_a[EB-1:0];
  assign oc      = word_a[2*EB-1:EB];
  assign nc1     = word_b[EB-1:0];
  // previous row shifts up, this cell becomes the previous row
  assign wr_word = {nc, s1_elev_q};

  // left-hand values of the row above and of this row, from the cell before
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_newer_q <= '0;
      tail0_q      <= '0;
      tail1_q      <= '0;
    end else if (s1_wr) begin
      prev_newer_q <= nc;
      tail0_q      <= s1_elev_q;
      tail1_q      <= tail0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // minimum decisions
  // ---------------------------------------------------------------------------
  // cell above, now that its lower neighbour has arrived
  assign dec_lower = s1_q.row_ge1 & (nc < s1_elev_q) &
                     (~s1_q.row_ge2   | (nc < oc)) &
                     (~s1_q.col_ge1   | (nc < prev_newer_q)) &
                     (~s1_q.has_right | (nc < nc1));

  // bottom row: cell to the left, now that its right neighbour has arrived
  assign dec_left  = s1_q.last_row & s1_q.col_ge1 & (tail0_q < s1_elev_q) &
                     (~s1_q.col_ge2 | (tail0_q < tail1_q)) &
                     (~s1_q.row_ge1 | (tail0_q < prev_newer_q));

  // bottom right corner cell itself
  assign dec_self  = s1_q.last_row & s1_q.last_col &
                     (~s1_q.col_ge1 | (s1_elev_q < tail0_q)) &
                     (~s1_q.row_ge1 | (s1_elev_q < nc));

  assign add_lower = dec_lower ? XW'(nc) + XW'(1)        : '0;
  assign add_left  = dec_left  ? XW'(tail0_q) + XW'(1)   : '0;
  assign add_self  = dec_self  ? XW'(s1_elev_q) + XW'(1) : '0;
  assign add_sum   = XW'(total_q) + add_lower + add_left + add_self;
  assign total_sat = (add_sum > XW'(glms_pkg::SUM_MAX)) ? glms_pkg::SUM_MAX
                                                        : add_sum[glms_pkg::SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cfg_hit) begin
      total_q <= '0;
    end else if (s1_wr) begin
      total_q <= s1_q.frame_end ? '0 : total_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_wr & s1_q.frame_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr & s1_q.frame_end) begin
      out_sum_q <= total_sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign minimum_sum_o = out_sum_q;

endmodule

// ----- hw/rtl/glms_checker.sv -----
`timescale 1ns / 1ps

module glms_checker #(
  parameter int unsigned MAX_WIDTH      = 128,
  parameter int unsigned ELEVATION_BITS = 4
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [ELEVATION_BITS-1:0]       elevation_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [glms_pkg::SUM_W-1:0]      minimum_sum_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0] sweep_cnt_q;
  logic          swept;

  // cycles since reset, saturating once the store sweep is over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (!swept) begin
      sweep_cnt_q <= sweep_cnt_q + CW'(1);
    end
  end

  assign swept = sweep_cnt_q == CW'(MAX_WIDTH);

  // a pending total is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(minimum_sum_o))
    else $error("frame total dropped or changed while stalled");

  // a stalled cell stays offered unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(elevation_i))
    else $error("stalled cell withdrawn or changed");

  // after the sweep the input only waits behind a blocked frame total
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swept && in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked frame total");

  // a new total comes from a cell that could move on in the cycle before
  a_total_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_stall_o))
    else $error("frame total appeared while the input was held");

  // no configuration write ever waits
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind grid_local_minimum_sum glms_checker #(
  .MAX_WIDTH      (MAX_WIDTH),
  .ELEVATION_BITS (ELEVATION_BITS)
) u_glms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .elevation_i   (elevation_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .minimum_sum_o (minimum_sum_o),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

// ----- dv/glms_frame_checker.sv -----
`timescale 1ns / 1ps

module glms_frame_checker #(
  parameter int unsigned MAX_WIDTH      = 128,
  parameter int unsigned ELEVATION_BITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [ELEVATION_BITS-1:0]         elevation_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [glms_pkg::SUM_W-1:0]        minimum_sum_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [glms_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [glms_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int unsigned                       pending_o,
  output int unsigned                       fail_count_o
);

  logic [glms_pkg::CFG_DATA_W-1:0] width_reg;
  logic [glms_pkg::CFG_DATA_W-1:0] height_reg;
  logic [ELEVATION_BITS-1:0]       older_row [MAX_WIDTH];
  logic [ELEVATION_BITS-1:0]       newer_row [MAX_WIDTH];
  logic [ELEVATION_BITS-1:0]       row_tail  [2];
  int unsigned                     col_pos;
  int unsigned                     row_pos;
  logic [glms_pkg::SUM_W-1:0]      frame_total;
  logic [glms_pkg::SUM_W-1:0]      expected_totals [$];
  int unsigned                     mismatches;

  function automatic void restart_frame();
    col_pos     = 0;
    row_pos     = 0;
    frame_total = '0;
  endfunction

  // saturating add of elevation plus one
  function automatic void add_minimum(input logic [ELEVATION_BITS-1:0] e);
    logic [glms_pkg::SUM_W:0] s;
    s = {1'b0, frame_total} + (glms_pkg::SUM_W + 1)'(e) + (glms_pkg::SUM_W + 1)'(1);
    frame_total = (s > {1'b0, glms_pkg::SUM_MAX}) ? glms_pkg::SUM_MAX
                                                  : s[glms_pkg::SUM_W-1:0];
  endfunction

  // one cell in raster order; returns 1 with the total when it closes a frame
  function automatic bit step_raster(input  logic [ELEVATION_BITS-1:0]  v,
                                     output logic [glms_pkg::SUM_W-1:0] total_out);
    int unsigned               w;
    int unsigned               h;
    int unsigned               c;
    int unsigned               r;
    logic [ELEVATION_BITS-1:0] e;
    bit                        last_row;
    total_out = '0;
    w = 32'(width_reg);
    h = 32'(height_reg);
    if (w == 0) w = 1;
    else if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h == 0) h = 1;
    else if (h > 32'(glms_pkg::HEIGHT_CAP)) h = 32'(glms_pkg::HEIGHT_CAP);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    last_row = (r + 1 == h);

    // cell above is now complete: this one is its lower neighbour
    if (r >= 1) begin
      e = newer_row[c];
      if (e < v && (r < 2 || e < older_row[c]) && (c == 0 || e < older_row[c-1]) &&
          (c + 1 >= w || e < newer_row[c+1]))
        add_minimum(e);
    end

    // bottom row is decided one column late, the row end at once
    if (last_row) begin
      if (c >= 1) begin
        e = row_tail[0];
        if (e < v && (c < 2 || e < row_tail[1]) && (r < 1 || e < older_row[c-1]))
          add_minimum(e);
      end
      if (c + 1 == w) begin
        if ((c < 1 || v < row_tail[0]) && (r < 1 || v < newer_row[c]))
          add_minimum(v);
      end
    end

    row_tail[1]  = row_tail[0];
    row_tail[0]  = v;
    older_row[c] = newer_row[c];
    newer_row[c] = v;

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) begin
        total_out = frame_total;
        restart_frame();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [glms_pkg::SUM_W-1:0] total;
    logic [glms_pkg::SUM_W-1:0] wanted;
    if (!rst_ni) begin
      width_reg  = glms_pkg::CFG_RESET;
      height_reg = glms_pkg::CFG_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      row_tail[0] = '0;
      row_tail[1] = '0;
      restart_frame();
      expected_totals.delete();
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i === 1'b1) begin
        if (cfg_index_i == glms_pkg::REG_FRAME_WIDTH) begin
          width_reg = cfg_data_i;
          restart_frame();
        end else if (cfg_index_i == glms_pkg::REG_FRAME_HEIGHT) begin
          height_reg = cfg_data_i;
          restart_frame();
        end
      end

      if (in_valid_i && in_stall_i === 1'b0) begin
        if (step_raster(elevation_i, total)) expected_totals.push_back(total);
      end

      if (out_valid_i === 1'b1 && !out_stall_i) begin
        if (expected_totals.size() == 0) begin
          $error("minimum_sum: expected none, actual %0d", minimum_sum_i);
          mismatches++;
        end else begin
          wanted = expected_totals.pop_front();
          if (minimum_sum_i !== wanted) begin
            $error("minimum_sum: expected %0d, actual %0d", wanted, minimum_sum_i);
            mismatches++;
          end
        end
      end

      pending_o    <= expected_totals.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- dv/tb_grid_local_minimum_sum.sv -----
`timescale 1ns / 1ps

module tb_grid_local_minimum_sum;

  localparam int unsigned MAX_W        = 128;
  localparam int unsigned ELEV_W       = 4;
  // quiet cycles tolerated; the longest correct one is the receiver hold-off
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned HOLD_OFF_LEN = 300;
  localparam int unsigned ITEM_TARGET  = 650;

  // indexes past the register list, which the block must ignore
  localparam logic [glms_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [glms_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // 3x3 opening frame: equal neighbours and minima in two corners
  localparam logic [ELEV_W-1:0] OPENING_GRID [9] = '{
    4'd0, 4'd0, 4'd15,
    4'd15, 4'd3, 4'd9,
    4'd2, 4'd15, 4'd0
  };

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_valid   = 1'b0;
  logic [ELEV_W-1:0]               elevation  = '0;
  logic                            out_stall  = 1'b0;
  logic                            cfg_valid  = 1'b0;
  logic [glms_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [glms_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  logic                            in_stall;
  logic                            out_valid;
  logic [glms_pkg::SUM_W-1:0]      minimum_sum;
  logic                            cfg_ready;

  int unsigned           frames_pending;
  int unsigned           fail_count;
  int unsigned           cells_sent        = 0;
  int unsigned           quiet_cycles      = 0;
  int unsigned           hold_off_requests = 0;
  int unsigned           hold_offs_served  = 0;
  bit                    send_idles        = 1'b1;
  bit                    stall_idles       = 1'b1;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_local_minimum_sum #(
    .MAX_WIDTH      (MAX_W),
    .ELEVATION_BITS (ELEV_W)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .elevation_i   (elevation),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .minimum_sum_o (minimum_sum),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // watches all three channels, predicts each frame total and compares
  glms_frame_checker #(
    .MAX_WIDTH      (MAX_W),
    .ELEVATION_BITS (ELEV_W)
  ) sum_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .elevation_i   (elevation),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .minimum_sum_i (minimum_sum),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .pending_o     (frames_pending),
    .fail_count_o  (fail_count)
  );

  // offer one cell, with a random gap in front when idling is on; returns at the
  // edge of the transfer with valid still high, so back-to-back cells need no toggle
  task automatic send_cell(input logic [ELEV_W-1:0] value);
    if (send_idles && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    elevation <= value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    cells_sent++;
  endtask

  // one register write; valid is left high for a following write
  task automatic write_register(input logic [glms_pkg::CFG_IDX_W-1:0]  index,
                                input logic [glms_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
  endtask

  // drop valid and wait for every outstanding frame total, then let the pipeline drain,
  // since a cut-short frame may still be in it with nothing to show
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // new frame geometry; each write also restarts the frame
  task automatic configure(input logic [glms_pkg::CFG_DATA_W-1:0] width_val,
                           input logic [glms_pkg::CFG_DATA_W-1:0] height_val);
    settle();
    write_register(glms_pkg::REG_FRAME_WIDTH, width_val);
    write_register(glms_pkg::REG_FRAME_HEIGHT, height_val);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_offs_served != hold_off_requests) begin
        hold_offs_served++;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end
      out_stall <= stall_idles && ($urandom_range(99) < 25);
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_grid_local_minimum_sum failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned cells;
    int unsigned spread;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // hand-picked 3x3 frame, all extremes of the elevation field
    configure(8'd3, 8'd3);
    foreach (OPENING_GRID[i]) send_cell(OPENING_GRID[i]);

    // zero width and height behave as 1: every cell is its own frame and a minimum
    configure(8'd0, 8'd0);
    send_cell(4'd15);
    send_cell(4'd0);

    // writes past the register list change nothing, not even the frame position
    settle();
    write_register(REG_SPARE_LO, 8'd5);
    write_register(REG_SPARE_HI, 8'd9);
    cfg_valid <= 1'b0;
    send_cell(4'd7);

    // frame cut short by a write: the total so far is thrown away, line stores kept
    configure(8'd4, 8'd2);
    repeat (5) send_cell(ELEV_W'($urandom_range(15)));
    configure(8'd2, 8'd2);
    repeat (4) send_cell(ELEV_W'($urandom_range(15)));

    // back-pressure: one-cell frames against a receiver that holds off for a long
    // stretch, so the output register and the slot behind it fill and input stalls
    send_idles = 1'b0;
    stall_idles <= 1'b0;
    configure(8'd1, 8'd1);
    hold_off_requests <= hold_off_requests + 1;
    repeat (40) send_cell(ELEV_W'($urandom_range(15)));

    // widest and tallest frames, with no idling on either side; register values
    // above the cap are clamped to it
    configure(8'd255, 8'd2);
    repeat (256) send_cell(ELEV_W'($urandom_range(15)));
    configure(8'd1, 8'd255);
    repeat (128) send_cell(ELEV_W'($urandom_range(3)));
    send_idles = 1'b1;
    stall_idles <= 1'b1;

    // random small frames, a few left unfinished; narrow value ranges give ties
    while (cells_sent < ITEM_TARGET) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      cells = w * h * $urandom_range(1, 4);
      if (w * h > 1 && $urandom_range(4) == 0) cells += $urandom_range(1, w * h - 1);
      case ($urandom_range(2))
        0: spread = 1;
        1: spread = 3;
        default: spread = 15;
      endcase
      configure(w[7:0], h[7:0]);
      repeat (cells) send_cell(ELEV_W'($urandom_range(spread)));
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_grid_local_minimum_sum passed");
    end else begin
      $display("tb_grid_local_minimum_sum failed");
    end
    $finish;
  end

endmodule
